FILE: sv/kts_pkg.sv
// Shared types, token kinds and character classes for the keyword token scanner.
// Depends on nothing; imported by the interfaces' users, controller and datapath.
package kts_pkg;

  // Token kinds
  localparam logic [4:0] KIND_EOF     = 5'd0;
  localparam logic [4:0] KIND_SEMI    = 5'd1;
  localparam logic [4:0] KIND_INTLIT  = 5'd2;
  localparam logic [4:0] KIND_PLUS    = 5'd3;
  localparam logic [4:0] KIND_PUB     = 5'd4;
  localparam logic [4:0] KIND_FN      = 5'd5;
  localparam logic [4:0] KIND_LET     = 5'd6;
  localparam logic [4:0] KIND_IDENT   = 5'd7;
  localparam logic [4:0] KIND_COLON   = 5'd8;
  localparam logic [4:0] KIND_U32     = 5'd9;
  localparam logic [4:0] KIND_EQ      = 5'd10;
  localparam logic [4:0] KIND_LPAREN  = 5'd11;
  localparam logic [4:0] KIND_RPAREN  = 5'd12;
  localparam logic [4:0] KIND_COMMA   = 5'd13;
  localparam logic [4:0] KIND_STAR    = 5'd14;
  localparam logic [4:0] KIND_LBRACE  = 5'd15;
  localparam logic [4:0] KIND_RBRACE  = 5'd16;
  localparam logic [4:0] KIND_IF      = 5'd17;
  localparam logic [4:0] KIND_LT      = 5'd18;
  localparam logic [4:0] KIND_RET     = 5'd19;
  localparam logic [4:0] KIND_EXTERN  = 5'd20;
  localparam logic [4:0] KIND_UNKNOWN = 5'd21;

  // Scan modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_NAME = 2'd2;

  localparam int unsigned KW_NUM = 7;
  localparam int unsigned KW_W   = 3;

  // Controller to datapath commands
  typedef struct packed {
    logic sel_pend;     // decode the held item instead of the input
    logic scan;         // apply the selected item to the scan state
    logic latch;        // hold the input item for a later replay
    logic flush_single; // emit the pending number or keyword
    logic rd_start;     // fetch the first buffered name character
    logic emit_char;    // emit one name character, fetch the next
    logic clr_tok;      // drop the pending name after its last character
  } kts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic need_flush;
    logic single_flush; // pending token flushes as one result
    logic last_char;
  } kts_sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
  endfunction

  // Punctuation kind, KIND_EOF when the byte is no punctuation
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h2b:   k = KIND_PLUS;
      8'h3b:   k = KIND_SEMI;
      8'h3a:   k = KIND_COLON;
      8'h3d:   k = KIND_EQ;
      8'h28:   k = KIND_LPAREN;
      8'h29:   k = KIND_RPAREN;
      8'h2c:   k = KIND_COMMA;
      8'h2a:   k = KIND_STAR;
      8'h7b:   k = KIND_LBRACE;
      8'h7d:   k = KIND_RBRACE;
      8'h3c:   k = KIND_LT;
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  // Keyword table: length, kind and text
  function automatic logic [2:0] kw_len(input logic [KW_W-1:0] k);
    logic [2:0] l;
    unique case (k)
      3'd0:    l = 3'd3;
      3'd1:    l = 3'd2;
      3'd2:    l = 3'd3;
      3'd3:    l = 3'd2;
      3'd4:    l = 3'd3;
      3'd5:    l = 3'd3;
      3'd6:    l = 3'd6;
      default: l = 3'd7;
    endcase
    return l;
  endfunction

  function automatic logic [4:0] kw_kind(input logic [KW_W-1:0] k);
    logic [4:0] r;
    unique case (k)
      3'd0:    r = KIND_LET;
      3'd1:    r = KIND_FN;
      3'd2:    r = KIND_U32;
      3'd3:    r = KIND_IF;
      3'd4:    r = KIND_RET;
      3'd5:    r = KIND_PUB;
      3'd6:    r = KIND_EXTERN;
      default: r = KIND_UNKNOWN;
    endcase
    return r;
  endfunction

  // Character at a position of a keyword, first character at position zero
  function automatic logic [7:0] kw_char(input logic [KW_W-1:0] k, input logic [2:0] pos);
    logic [47:0] txt;
    logic [7:0]  ch;
    txt = '0;
    unique case (k)
      3'd0:    txt = {"let", 24'h0};
      3'd1:    txt = {"fn", 32'h0};
      3'd2:    txt = {"u32", 24'h0};
      3'd3:    txt = {"if", 32'h0};
      3'd4:    txt = {"ret", 24'h0};
      3'd5:    txt = {"pub", 24'h0};
      3'd6:    txt = "extern";
      default: txt = '0;
    endcase
    unique case (pos)
      3'd0:    ch = txt[47:40];
      3'd1:    ch = txt[39:32];
      3'd2:    ch = txt[31:24];
      3'd3:    ch = txt[23:16];
      3'd4:    ch = txt[15:8];
      3'd5:    ch = txt[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/kts_if.sv
// Valid/ready channels of the keyword token scanner: source bytes in, tokens out.
// Standalone; widths follow the package's token field layout.
interface kts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] src_byte;
  logic       end_of_input;

  modport source (output valid, output src_byte, output end_of_input, input ready);
  modport sink   (input valid, input src_byte, input end_of_input, output ready);
endinterface

interface kts_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [63:0] int_value;
  logic [7:0]  name_char;
  logic        last_of_token;
  logic        name_truncated;

  modport source (output valid, output kind, output int_value, output name_char,
                  output last_of_token, output name_truncated, input ready);
  modport sink   (input valid, input kind, input int_value, input name_char,
                  input last_of_token, input name_truncated, output ready);
endinterface

FILE: sv/kts_ctrl.sv
// Sequencer of the keyword token scanner: accepts bytes and orders flush, replay
// and name character emission. Depends on kts_pkg command and status types.
module kts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  kts_pkg::kts_sts_t sts_i,
  output kts_pkg::kts_cmd_t cmd_o
);
  import kts_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REPLAY = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE) && sts_i.slot_free;
  assign accept     = in_valid_i && in_ready_o;

  // Decode state into datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (sts_i.need_flush) begin
            cmd_o.latch = 1'b1;
            if (sts_i.single_flush) begin
              cmd_o.flush_single = 1'b1;
              state_d            = ST_REPLAY;
            end else begin
              cmd_o.rd_start = 1'b1;
              state_d        = ST_EMIT;
            end
          end else begin
            cmd_o.scan = 1'b1;
          end
        end
      end
      ST_REPLAY: begin
        cmd_o.sel_pend = 1'b1;
        if (sts_i.slot_free) begin
          cmd_o.scan = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_char = 1'b1;
          if (sts_i.last_char) begin
            cmd_o.clr_tok = 1'b1;
            state_d       = ST_REPLAY;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/kts_datapath.sv
// Datapath of the keyword token scanner: scan state, number accumulator, name
// buffer memory, keyword match tracking and output register. Uses kts_pkg.
module kts_datapath #(
  parameter int unsigned MAX_NAME_CHARS = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        in_byte_i,
  input  logic              in_eoi_i,
  input  logic              out_ready_i,
  input  kts_pkg::kts_cmd_t cmd_i,
  output kts_pkg::kts_sts_t sts_o,
  output logic              out_valid_o,
  output logic [4:0]        out_kind_o,
  output logic [63:0]       out_int_o,
  output logic [7:0]        out_char_o,
  output logic              out_last_o,
  output logic              out_trunc_o
);
  import kts_pkg::*;

  localparam int unsigned LEN_W = $clog2(MAX_NAME_CHARS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_NAME_CHARS);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_NAME_CHARS);

  logic [1:0]        mode_q, mode_d;
  logic [63:0]       accum_q, accum_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [KW_NUM-1:0] kw_match_q, kw_match_d;
  logic [7:0]        pend_byte_q;
  logic              pend_eoi_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [7:0]        rdata_q;
  logic [7:0]        name_mem [MAX_NAME_CHARS];

  logic              out_valid_q;
  logic [4:0]        out_kind_q, out_kind_d;
  logic [63:0]       out_int_q, out_int_d;
  logic [7:0]        out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              out_trunc_q, out_trunc_d;
  logic              out_load;

  logic [7:0]        sel_byte;
  logic              sel_eoi;
  logic              cont_num, cont_name, name_start;
  logic [4:0]        pkind;
  logic [67:0]       mul_sum;
  logic [63:0]       accum_next;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              kw_hit;
  logic [4:0]        kw_hit_kind;
  logic              slot_free;

  // Select the live input or the held item
  assign sel_byte  = cmd_i.sel_pend ? pend_byte_q : in_byte_i;
  assign sel_eoi   = cmd_i.sel_pend ? pend_eoi_q : in_eoi_i;
  assign cont_num  = !sel_eoi && (mode_q == MODE_NUM) && is_digit(sel_byte);
  assign cont_name = !sel_eoi && (mode_q == MODE_NAME) &&
                     (is_letter(sel_byte) || is_digit(sel_byte) || (sel_byte == 8'h5f));
  assign name_start = (is_letter(sel_byte) || (sel_byte == 8'h5f));
  assign pkind     = punct_kind(sel_byte);

  // Saturating accumulate: value * 10 + digit
  assign mul_sum    = {1'b0, accum_q, 3'b000} + {3'b000, accum_q, 1'b0} +
                      {64'h0, sel_byte[3:0]};
  assign accum_next = (mul_sum[67:64] != 4'h0) ? '1 : mul_sum[63:0];

  // Keyword decision for the pending name
  always_comb begin
    kw_hit      = 1'b0;
    kw_hit_kind = KIND_UNKNOWN;
    for (int unsigned k = 0; k < KW_NUM; k++) begin
      if (kw_match_q[k] && (len_q == LEN_W'(kw_len(KW_W'(k))))) begin
        kw_hit      = !ovf_q;
        kw_hit_kind = kw_kind(KW_W'(k));
      end
    end
  end

  assign slot_free         = !out_valid_q || out_ready_i;
  assign sts_o.slot_free    = slot_free;
  assign sts_o.need_flush   = (mode_q != MODE_IDLE) && !cont_num && !cont_name;
  assign sts_o.single_flush = (mode_q == MODE_NUM) || kw_hit;
  assign sts_o.last_char    = (LEN_W'(rd_idx_q) + LEN_W'(1)) == len_q;

  // Scan state update and result selection
  always_comb begin
    mode_d      = mode_q;
    accum_d     = accum_q;
    len_d       = len_q;
    ovf_d       = ovf_q;
    kw_match_d  = kw_match_q;
    wr_en       = 1'b0;
    wr_addr     = len_q[IDX_W-1:0];
    out_load    = 1'b0;
    out_kind_d  = KIND_EOF;
    out_int_d   = '0;
    out_char_d  = '0;
    out_last_d  = 1'b1;
    out_trunc_d = 1'b0;
    if (cmd_i.flush_single) begin
      out_load   = 1'b1;
      out_kind_d = (mode_q == MODE_NUM) ? KIND_INTLIT : kw_hit_kind;
      out_int_d  = (mode_q == MODE_NUM) ? accum_q : '0;
      mode_d     = MODE_IDLE;
      accum_d    = '0;
      len_d      = '0;
      ovf_d      = 1'b0;
    end else if (cmd_i.emit_char) begin
      out_load    = 1'b1;
      out_kind_d  = KIND_IDENT;
      out_char_d  = rdata_q;
      out_last_d  = sts_o.last_char;
      out_trunc_d = ovf_q;
      if (cmd_i.clr_tok) begin
        mode_d = MODE_IDLE;
        len_d  = '0;
        ovf_d  = 1'b0;
      end
    end else if (cmd_i.scan) begin
      priority if (sel_eoi) begin
        out_load = 1'b1;
        mode_d   = MODE_IDLE;
      end else if (cont_num) begin
        accum_d = accum_next;
      end else if (cont_name) begin
        if (len_q < LEN_MAX) begin
          wr_en = 1'b1;
          len_d = len_q + LEN_W'(1);
          for (int unsigned k = 0; k < KW_NUM; k++) begin
            if (len_q < LEN_W'(kw_len(KW_W'(k)))) begin
              kw_match_d[k] = kw_match_q[k] &&
                              (kw_char(KW_W'(k), len_q[2:0]) == sel_byte);
            end else begin
              kw_match_d[k] = 1'b0;
            end
          end
        end else begin
          ovf_d = 1'b1;
        end
      end else if (is_space(sel_byte)) begin
        mode_d = MODE_IDLE;
      end else if (pkind != KIND_EOF) begin
        out_load   = 1'b1;
        out_kind_d = pkind;
      end else if (is_digit(sel_byte)) begin
        mode_d  = MODE_NUM;
        accum_d = {60'h0, sel_byte[3:0]};
      end else if (name_start) begin
        mode_d  = MODE_NAME;
        wr_en   = 1'b1;
        wr_addr = '0;
        len_d   = LEN_W'(1);
        ovf_d   = 1'b0;
        for (int unsigned k = 0; k < KW_NUM; k++) begin
          kw_match_d[k] = (kw_char(KW_W'(k), 3'd0) == sel_byte);
        end
      end else begin
        out_load   = 1'b1;
        out_kind_d = KIND_UNKNOWN;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      accum_q     <= '0;
      len_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      accum_q <= accum_d;
      len_q   <= len_d;
      ovf_q   <= ovf_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and held item
  always_ff @(posedge clk_i) begin
    kw_match_q <= kw_match_d;
    if (cmd_i.latch) begin
      pend_byte_q <= in_byte_i;
      pend_eoi_q  <= in_eoi_i;
    end
    if (out_load) begin
      out_kind_q  <= out_kind_d;
      out_int_q   <= out_int_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      out_trunc_q <= out_trunc_d;
    end
  end

  // Name buffer: one write port, one registered read port
  assign rd_en   = cmd_i.rd_start || (cmd_i.emit_char && !sts_o.last_char);
  assign rd_addr = cmd_i.rd_start ? '0 : rd_idx_q + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      name_mem[wr_addr] <= sel_byte;
    end
    if (rd_en) begin
      rdata_q  <= name_mem[rd_addr];
      rd_idx_q <= rd_addr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_int_o   = out_int_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;
  assign out_trunc_o = out_trunc_q;

  // Name length never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= LEN_MAX)
    else $error("name length beyond buffer depth");

  // Overflow only after the buffer has filled
  assert property (@(posedge clk_i) disable iff (!rst_ni) ovf_q |-> (len_q == LEN_MAX))
    else $error("overflow flag set with room left in buffer");

  // Outside a name no name state lingers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != MODE_NAME) |-> ((len_q == '0) && !ovf_q))
    else $error("stale name state outside name mode");

  // A name always holds at least one character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_NAME) |-> (len_q != '0))
    else $error("empty name in name mode");

endmodule

FILE: sv/keyword_token_scanner_unit.sv
// Keyword token scanner: one source byte per transfer in, tokens out.
// Throughput without output stalls: one byte per cycle while the scanner is idle; a byte ending
// a number or keyword is held while that token flushes and is then replayed, and a byte ending a
// name is held through the buffer fetch and the name's characters and is then replayed.
// Every token is driven from a registered output.
// Reset (rst_ni low) returns the scanner to idle; the name buffer is not cleared.
module keyword_token_scanner_unit #(
  parameter int unsigned MAX_NAME_CHARS = 31
) (
  input  logic clk_i,
  input  logic rst_ni,
  kts_in_if.sink    in_i,
  kts_out_if.source out_o
);
  import kts_pkg::*;

  kts_cmd_t cmd;
  kts_sts_t sts;

  kts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kts_datapath #(
    .MAX_NAME_CHARS (MAX_NAME_CHARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_byte_i   (in_i.src_byte),
    .in_eoi_i    (in_i.end_of_input),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_kind_o  (out_o.kind),
    .out_int_o   (out_o.int_value),
    .out_char_o  (out_o.name_char),
    .out_last_o  (out_o.last_of_token),
    .out_trunc_o (out_o.name_truncated)
  );

endmodule
